// ----- rtl/core/ssw_pkg.sv -----
// Shared constants, codes and the helper function of the scrolling sine buffer.
package ssw_pkg;

  localparam int OP_W       = 1;
  localparam int NOISE_W    = 8;
  localparam int COLUMN_W   = 8;
  localparam int SAMPLE_W   = 8;
  localparam int IN_DATA_W  = NOISE_W + COLUMN_W;
  localparam int OUT_DATA_W = SAMPLE_W;

  localparam logic [OP_W-1:0] OP_TICK = 1'b0;
  localparam logic [OP_W-1:0] OP_READ = 1'b1;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 14;
  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PAUSED     = 2'd2;

  localparam int STEP_W = 14;
  localparam int AMP_W  = 6;
  localparam logic [STEP_W-1:0] STEP_MIN   = 14'd131;
  localparam logic [STEP_W-1:0] STEP_MAX   = 14'd13107;
  localparam logic [STEP_W-1:0] STEP_RESET = 14'd2621;
  localparam logic [AMP_W-1:0]  AMP_MIN    = 6'd5;
  localparam logic [AMP_W-1:0]  AMP_MAX    = 6'd55;
  localparam logic [AMP_W-1:0]  AMP_RESET  = 6'd40;

  localparam int PHASE_W = 16;
  localparam int SINE_W  = 16;

  localparam int ROT_STEPS = 14;
  localparam int ROT_CNT_W = $clog2(ROT_STEPS);
  localparam int ANG_W     = 17;

  // sample denominator 32768 * 500; bias keeps the dividend non-negative
  localparam logic [31:0] SCALE_DEN = 32'd16384000;
  localparam int          DIV_BIAS  = 128;
  localparam longint      DIV_OFFS  = longint'(DIV_BIAS) * longint'(SCALE_DEN);

  // SCALE_DEN = 125 << 17: n / SCALE_DEN = ((n >> 17) * 33555) >> 22, exact for n < 2^32
  localparam int              DEN_SH    = 17;
  localparam int              RECIP_W   = 16;
  localparam logic [RECIP_W-1:0] DEN_RECIP = 16'd33555;
  localparam int              RECIP_SH  = 22;
  localparam int              QUO_W     = 9;

  function automatic logic signed [ANG_W-1:0] rot_angle(input logic [ROT_CNT_W-1:0] i);
    logic signed [ANG_W-1:0] a;
    case (i)
      4'd0:    a = 17'sd8192;
      4'd1:    a = 17'sd4836;
      4'd2:    a = 17'sd2555;
      4'd3:    a = 17'sd1297;
      4'd4:    a = 17'sd651;
      4'd5:    a = 17'sd326;
      4'd6:    a = 17'sd163;
      4'd7:    a = 17'sd81;
      4'd8:    a = 17'sd41;
      4'd9:    a = 17'sd20;
      4'd10:   a = 17'sd10;
      4'd11:   a = 17'sd5;
      4'd12:   a = 17'sd3;
      4'd13:   a = 17'sd1;
      default: a = 17'sd0;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/core/ssw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ssw_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/ssw_cordic.sv -----
// Iterative rotation-mode CORDIC sine, one micro-rotation per cycle.
module ssw_cordic #(
  parameter int SINE_TABLE_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [ssw_pkg::PHASE_W-1:0]         phase,
  output logic                                done,
  output logic signed [ssw_pkg::SINE_W-1:0]   sine
);
  import ssw_pkg::*;

  localparam int DROP = PHASE_W - SINE_TABLE_BITS;
  localparam logic [PHASE_W-1:0] QMASK = 16'hFFFF << DROP;
  localparam int XY_W = 18;

  logic [PHASE_W-1:0]      q;
  logic signed [ANG_W-1:0] a0, af;
  logic signed [XY_W-1:0]  x_r, x_nxt, y_r, y_nxt, xs, ys;
  logic signed [ANG_W-1:0] a_r, a_nxt;
  logic [ROT_CNT_W-1:0]    i_r, i_nxt;
  logic                    busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    q  = phase & QMASK;
    a0 = $signed({q[PHASE_W-1], q});
    if (a0 > 17'sd16384) begin
      af = 17'sd32768 - a0;
    end else if (a0 < -17'sd16384) begin
      af = -17'sd32768 - a0;
    end else begin
      af = a0;
    end
  end

  always_comb begin
    xs       = x_r >>> i_r;
    ys       = y_r >>> i_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    a_nxt    = a_r;
    i_nxt    = i_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = 18'sd19898;
      y_nxt    = 18'sd0;
      a_nxt    = af;
      i_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (a_r >= 0) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        a_nxt = a_r - rot_angle(i_r);
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        a_nxt = a_r + rot_angle(i_r);
      end
      i_nxt = i_r + 1'b1;
      if (i_r == ROT_CNT_W'(ROT_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    a_r <= a_nxt;
    i_r <= i_nxt;
  end

  always_comb begin
    if (y_r > 18'sd32767) begin
      sine = 16'sd32767;
    end else if (y_r < -18'sd32767) begin
      sine = -16'sd32767;
    end else begin
      sine = SINE_W'(y_r);
    end
  end

  assign done = done_r;

endmodule

// ----- rtl/core/ssw_scale.sv -----
// Sample scaling: sine and noise weighting, amplitude multiply, divide by the fixed denominator, clamp.
module ssw_scale #(
  parameter int CENTER = 120,
  parameter int HEIGHT = 240
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [ssw_pkg::SINE_W-1:0]  sine,
  input  logic signed [ssw_pkg::NOISE_W-1:0] noise,
  input  logic [ssw_pkg::AMP_W-1:0]          amp,
  output logic                               done,
  output logic [ssw_pkg::SAMPLE_W-1:0]       sample_y
);
  import ssw_pkg::*;

  localparam int W_W    = 26;
  localparam int P_W    = W_W + AMP_W + 1;
  localparam int V_W    = 10;
  localparam int M_W    = 32 - DEN_SH;
  localparam int PROD_W = M_W + RECIP_W;
  localparam logic signed [W_W-1:0] SINE_K = 26'sd500;
  localparam int NOISE_SH = 15;

  logic signed [W_W-1:0] w_r, w_nxt;
  logic signed [P_W-1:0] p_r, p_nxt;
  logic [31:0]           rem_r, rem_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [QUO_W-1:0]      quo;
  logic                  s1_r, s2_r, s3_r, done_r;
  logic signed [V_W-1:0] val;

  always_comb begin
    w_nxt    = W_W'(sine) * SINE_K + (W_W'(noise) <<< NOISE_SH);
    p_nxt    = P_W'(w_r) * P_W'($signed({1'b0, amp}));
    rem_nxt  = 32'(p_r + P_W'(DIV_OFFS));
    // shift out the power of two, then reciprocal multiply for the factor 125
    prod_nxt = PROD_W'(rem_r[31:DEN_SH]) * PROD_W'(DEN_RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      s3_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_r   <= start;
      s2_r   <= s1_r;
      s3_r   <= s2_r;
      done_r <= s3_r;
    end
    w_r    <= w_nxt;
    p_r    <= p_nxt;
    rem_r  <= rem_nxt;
    prod_r <= prod_nxt;
  end

  assign quo = prod_r[RECIP_SH +: QUO_W];

  always_comb begin
    val = V_W'(CENTER - DIV_BIAS) + $signed({1'b0, quo});
    if (val < 10'sd5) begin
      sample_y = 8'd5;
    end else if (val > V_W'(HEIGHT - 5)) begin
      sample_y = SAMPLE_W'(HEIGHT - 5);
    end else begin
      sample_y = SAMPLE_W'(val);
    end
  end

  assign done = done_r;

endmodule

// ----- rtl/core/scrolling_sine_waveform_buffer_core.sv -----
// Scrolling sine waveform buffer: control, configuration and column store.
//
// Input channel in_*: in_tuser carries the operation (tick or read), in_tdata
// the tick noise and the column to read. Each item gives one result on out_*:
// out_tdata is the sample, out_tuser flags a tick that was ignored while paused.
// A tick advances the phase, runs a 14-step CORDIC sine and a 4-stage scale
// (multiply, reciprocal-multiply divide), then writes the sample as the newest
// column and returns it as its result. A read or a paused tick reads the column
// RAM and answers. One item is in work at a time; in_tready is high again once
// the result is in the output register, so the next item is taken while the
// result still waits. While out_tready is low a finished result waits in the
// output register, the next item may still be taken and then waits in S_PUSH,
// and any further item is held off. Configuration writes on cfg_* take effect
// at once; the user must make them only while idle, and the block itself does
// not enforce this. Phase step and amplitude are saturated to their legal ranges.
// Reset (rst_n low, synchronous) clears the phase, the oldest-column pointer
// and the per-column valid bits, so every column reads as CENTER; registers
// return to their defaults. No clearing pass is needed.
module scrolling_sine_waveform_buffer_core #(
  parameter int WIDTH           = 128,
  parameter int CENTER          = 120,
  parameter int HEIGHT          = 240,
  parameter int SINE_TABLE_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ssw_pkg::IN_DATA_W-1:0]     in_tdata,   // noise, column
  input  logic [ssw_pkg::OP_W-1:0]          in_tuser,   // operation
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ssw_pkg::OUT_DATA_W-1:0]    out_tdata,  // sample_y
  output logic [0:0]                        out_tuser,  // was_paused
  input  logic                              cfg_wr_en,
  input  logic [ssw_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [ssw_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
  import ssw_pkg::*;

  localparam int PTR_W = $clog2(WIDTH);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SINE  = 5'b00010,
    S_SCALE = 5'b00100,
    S_RD    = 5'b01000,
    S_PUSH  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [AMP_W-1:0]   amp_r, amp_nxt;
  logic               paused_r, paused_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [PTR_W-1:0]   oldest_r, oldest_nxt;
  logic [WIDTH-1:0]   vld_r, vld_nxt;

  logic signed [NOISE_W-1:0] noise_r, noise_nxt;
  logic                      rd_center_r, rd_center_nxt;
  logic                      rd_vld_r, rd_vld_nxt;
  logic [SAMPLE_W-1:0]       res_y_r, res_y_nxt;
  logic                      res_was_r, res_was_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0]       out_y_r, out_y_nxt;
  logic                      out_was_r, out_was_nxt;

  logic [STEP_W-1:0]   cfg_step;
  logic [AMP_W-1:0]    cfg_amp;
  logic                accept;
  logic [OP_W-1:0]     in_op;
  logic [COLUMN_W-1:0] in_col;
  logic [PTR_W:0]      rd_sum;
  logic [PTR_W-1:0]    rd_addr, newest;
  logic                col_oob;
  logic [PHASE_W-1:0]  phase_adv;
  logic                cordic_start, cordic_done, scale_done;
  logic signed [SINE_W-1:0] sine;
  logic [SAMPLE_W-1:0] scale_y, ram_rdata, rd_y;
  logic                ram_we;
  logic                out_free;

  // configuration saturation
  always_comb begin
    cfg_step = cfg_wr_data[STEP_W-1:0];
    if (cfg_step < STEP_MIN) begin
      cfg_step = STEP_MIN;
    end else if (cfg_step > STEP_MAX) begin
      cfg_step = STEP_MAX;
    end
    cfg_amp = cfg_wr_data[AMP_W-1:0];
    if (cfg_amp < AMP_MIN) begin
      cfg_amp = AMP_MIN;
    end else if (cfg_amp > AMP_MAX) begin
      cfg_amp = AMP_MAX;
    end
  end

  always_comb begin
    step_nxt   = step_r;
    amp_nxt    = amp_r;
    paused_nxt = paused_r;
    if (cfg_wr_en) begin
      case (cfg_addr)
        REG_PHASE_STEP: step_nxt   = cfg_step;
        REG_AMPLITUDE:  amp_nxt    = cfg_amp;
        REG_PAUSED:     paused_nxt = cfg_wr_data[0];
        default:        ;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_op     = in_tuser;
  assign in_col    = in_tdata[IN_DATA_W-1:NOISE_W];
  assign phase_adv = phase_r + PHASE_W'(step_r);
  assign col_oob   = ({1'b0, in_col} >= 9'(WIDTH));
  assign rd_sum    = {1'b0, oldest_r} + {1'b0, in_col[PTR_W-1:0]};
  assign newest    = (oldest_r == '0) ? PTR_W'(WIDTH - 1) : oldest_r - 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    if (in_op == OP_READ) begin
      if (rd_sum >= (PTR_W + 1)'(WIDTH)) begin
        rd_addr = PTR_W'(rd_sum - (PTR_W + 1)'(WIDTH));
      end else begin
        rd_addr = rd_sum[PTR_W-1:0];
      end
    end else begin
      rd_addr = newest;
    end
  end

  assign cordic_start = accept && (in_op == OP_TICK) && !paused_r;
  assign ram_we       = (state_r == S_SCALE) && scale_done;
  assign rd_y         = (rd_center_r || !rd_vld_r) ? SAMPLE_W'(CENTER) : ram_rdata;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    oldest_nxt    = oldest_r;
    vld_nxt       = vld_r;
    noise_nxt     = noise_r;
    rd_center_nxt = rd_center_r;
    rd_vld_nxt    = rd_vld_r;
    res_y_nxt     = res_y_r;
    res_was_nxt   = res_was_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_y_nxt     = out_y_r;
    out_was_nxt   = out_was_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          noise_nxt     = $signed(in_tdata[NOISE_W-1:0]);
          rd_center_nxt = (in_op == OP_READ) && col_oob;
          rd_vld_nxt    = vld_r[rd_addr];
          res_was_nxt   = (in_op == OP_TICK) && paused_r;
          if (cordic_start) begin
            phase_nxt = phase_adv;
            state_nxt = S_SINE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_SINE: begin
        if (cordic_done) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        if (scale_done) begin
          vld_nxt[oldest_r] = 1'b1;
          oldest_nxt = (oldest_r == PTR_W'(WIDTH - 1)) ? '0 : oldest_r + 1'b1;
          res_y_nxt  = scale_y;
          state_nxt  = S_PUSH;
        end
      end
      S_RD: begin
        res_y_nxt = rd_y;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_y_nxt     = res_y_r;
          out_was_nxt   = res_was_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_RESET;
      amp_r       <= AMP_RESET;
      paused_r    <= 1'b0;
      phase_r     <= '0;
      oldest_r    <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      amp_r       <= amp_nxt;
      paused_r    <= paused_nxt;
      phase_r     <= phase_nxt;
      oldest_r    <= oldest_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    noise_r     <= noise_nxt;
    rd_center_r <= rd_center_nxt;
    rd_vld_r    <= rd_vld_nxt;
    res_y_r     <= res_y_nxt;
    res_was_r   <= res_was_nxt;
    out_y_r     <= out_y_nxt;
    out_was_r   <= out_was_nxt;
  end

  ssw_ram #(
    .DW    (SAMPLE_W),
    .DEPTH (WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (oldest_r),
    .wdata (scale_y),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  ssw_cordic #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .phase (phase_adv),
    .done  (cordic_done),
    .sine  (sine)
  );

  ssw_scale #(
    .CENTER (CENTER),
    .HEIGHT (HEIGHT)
  ) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cordic_done),
    .sine     (sine),
    .noise    (noise_r),
    .amp      (amp_r),
    .done     (scale_done),
    .sample_y (scale_y)
  );

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_y_r;
  assign out_tuser[0] = out_was_r;

endmodule

// ----- tb/scrolling_sine_waveform_buffer_core_test.sv -----
// Self-checking stream testbench for the scrolling sine waveform buffer core.
module scrolling_sine_waveform_buffer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ssw_pkg::*;

  localparam int COLS     = 128;
  localparam int MID      = 120;
  localparam int TOP      = 240;
  localparam int TBL_BITS = 8;
  localparam longint DEN  = 64'd16384000;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;
  localparam int ANGLES [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5,
                                 3, 1};

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [7:0]      noise;
    logic [7:0]      column;
  } item_t;

  typedef struct packed {
    logic [7:0] y;
    logic       was_paused;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  always #2 clk = ~clk;

  scrolling_sine_waveform_buffer_core #(
    .WIDTH(COLS), .CENTER(MID), .HEIGHT(TOP), .SINE_TABLE_BITS(TBL_BITS)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
  );

  // predictor state
  logic [STEP_W-1:0] step_q;
  logic [AMP_W-1:0]  amp_q;
  logic              pause_q;
  logic [15:0]       phase_q;
  logic [6:0]        oldest_q;
  logic [7:0]        columns_q [COLS];

  item_t   pending [$];
  sample_t sample_due [$];
  int n_queued, n_taken, n_results, n_errors;
  int n_ticks, n_frozen, n_reads, n_far_reads, n_settings;
  bit in_taken;

  function automatic int cordic_sine(logic [15:0] ph);
    int a, x, y, nx;
    logic [15:0] q;
    q = (ph >> (16 - TBL_BITS)) << (16 - TBL_BITS);
    a = (q >= 16'd32768) ? int'(q) - 65536 : int'(q);
    x = 19898;
    y = 0;
    if (a > 16384) a = 32768 - a;
    else if (a < -16384) a = -32768 - a;
    for (int i = 0; i < 14; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        a -= ANGLES[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        a += ANGLES[i];
      end
      x = nx;
    end
    if (y > 32767) y = 32767;
    if (y < -32767) y = -32767;
    return y;
  endfunction

  function automatic logic [7:0] scaled_sample(logic signed [7:0] noise);
    longint v, amp;
    amp = longint'(amp_q);
    v = longint'(MID) * DEN + longint'(cordic_sine(phase_q)) * amp * 500
        + longint'(noise) * amp * 32768;
    if (v > longint'(TOP - 5) * DEN) v = longint'(TOP - 5) * DEN;
    if (v < 5 * DEN) v = 5 * DEN;
    return 8'(v / DEN);
  endfunction

  function automatic sample_t predict_sample(item_t it);
    sample_t r;
    r.was_paused = 1'b0;
    if (it.op == OP_TICK) begin
      if (pause_q) begin
        r.y = columns_q[oldest_q - 7'd1];
        r.was_paused = 1'b1;
        n_frozen++;
      end else begin
        phase_q = phase_q + 16'(step_q);
        r.y = scaled_sample(it.noise);
        columns_q[oldest_q] = r.y;
        oldest_q = oldest_q + 7'd1;
        n_ticks++;
      end
    end else begin
      n_reads++;
      if (it.column >= COLS) begin
        r.y = 8'(MID);
        n_far_reads++;
      end else begin
        r.y = columns_q[oldest_q + it.column[6:0]];
      end
    end
    return r;
  endfunction

  function automatic void apply_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_PHASE_STEP: step_q = (val < STEP_MIN) ? STEP_MIN : (val > STEP_MAX) ? STEP_MAX : val;
      REG_AMPLITUDE: begin
        amp_q = (val[5:0] < AMP_MIN) ? AMP_MIN : (val[5:0] > AMP_MAX) ? AMP_MAX : val[5:0];
      end
      REG_PAUSED: pause_q = val[0];
      default: ;
    endcase
  endfunction

  // monitor, checker and predictor
  always @(posedge clk) begin
    sample_t want;
    if (!rst_n) begin
      step_q = STEP_RESET;
      amp_q = AMP_RESET;
      pause_q = 1'b0;
      phase_q = '0;
      oldest_q = '0;
      foreach (columns_q[i]) columns_q[i] = 8'(MID);
      in_taken = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (sample_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result: y %0d paused %0b", out_tdata,
                                       out_tuser);
        end else begin
          want = sample_due.pop_front();
          if (want.y !== out_tdata || want.was_paused !== out_tuser[0]) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("mismatch at result %0d: y exp %0d got %0d, paused exp %0b got %0b",
                       n_results, want.y, out_tdata, want.was_paused, out_tuser);
            end
          end
        end
      end
      if (cfg_wr_en) apply_reg(cfg_addr, cfg_wr_data);
      in_taken = in_tvalid && in_tready;
      if (in_taken) begin
        n_taken++;
        sample_due.push_back(predict_sample({in_tuser, in_tdata[7:0], in_tdata[15:8]}));
      end
    end
  end

  // sender: bursts with random gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk) begin
    item_t it;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
        it = pending.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= it.op;
        in_tdata <= {it.column, it.noise};
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern picked at random from four modes
  int rx_cyc = 0;
  int rx_mode = 0;
  always @(negedge clk) begin
    if (rx_cyc % 50 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 2) != 0);
      2: out_tready <= ((rx_cyc % 9) >= 4);
      default: out_tready <= ((rx_cyc % 50) >= 12);
    endcase
    rx_cyc++;
  end

  task automatic add_item(logic [OP_W-1:0] op, logic [7:0] noise, logic [7:0] column);
    item_t it;
    it.op = op;
    it.noise = noise;
    it.column = column;
    pending.push_back(it);
    n_queued++;
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (n_taken != n_queued || sample_due.size() != 0);
  endtask

  task automatic set_regs(logic [CFG_DATA_W-1:0] step, logic [CFG_DATA_W-1:0] amp,
                          logic [CFG_DATA_W-1:0] pause);
    cfg_write(REG_PHASE_STEP, step);
    cfg_write(REG_AMPLITUDE, amp);
    cfg_write(REG_PAUSED, pause);
    n_settings++;
  endtask

  task automatic random_items(int count);
    logic [7:0] noise, column;
    for (int i = 0; i < count; i++) begin
      noise = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 199) - 100);
      column = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, COLS - 1));
      add_item(($urandom_range(0, 9) < 6) ? OP_TICK : OP_READ, noise, column);
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] step, amp;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset contents, range edges of noise and column
    add_item(OP_READ, 8'h00, 8'd0);
    add_item(OP_READ, 8'hFF, 8'd127);
    add_item(OP_READ, 8'h00, 8'd128);
    add_item(OP_READ, 8'h00, 8'd255);
    add_item(OP_TICK, 8'h80, 8'hFF);
    add_item(OP_TICK, 8'h7F, 8'h00);
    add_item(OP_TICK, 8'h00, 8'h00);
    add_item(OP_TICK, 8'h9C, 8'h00);
    add_item(OP_TICK, 8'h63, 8'h00);
    add_item(OP_READ, 8'h00, 8'd127);
    add_item(OP_READ, 8'h00, 8'd0);
    drain();

    // saturation of both registers at the low and high ends, unused index
    set_regs(14'd0, 14'd0, 14'd0);
    add_item(OP_TICK, 8'h80, 8'h00);
    add_item(OP_TICK, 8'h7F, 8'h00);
    drain();
    set_regs(14'h3FFF, 14'h3F, 14'd0);
    cfg_write(REG_SPARE, 14'h1555);
    for (int i = 0; i < 4; i++) add_item(OP_TICK, (i % 2) ? 8'h7F : 8'h80, 8'h00);
    drain();

    // frozen ticks, then resume via a write with bit 0 clear
    set_regs(14'd131, 14'd5, 14'h3FFF);
    add_item(OP_TICK, 8'h55, 8'h00);
    add_item(OP_TICK, 8'hAA, 8'h00);
    add_item(OP_READ, 8'h00, 8'd127);
    drain();
    set_regs(14'd13107, 14'd55, 14'h3FFE);
    add_item(OP_TICK, 8'h00, 8'h00);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 2))
        0: step = 14'd131;
        1: step = 14'd13107;
        default: step = 14'($urandom_range(0, 16383));
      endcase
      case ($urandom_range(0, 2))
        0: amp = 14'd5;
        1: amp = 14'd55;
        default: amp = 14'($urandom_range(0, 63));
      endcase
      set_regs(step, amp, ($urandom_range(0, 4) == 0) ? 14'd1 : 14'd0);
      random_items(92);
      drain();
    end

    repeat (40) @(negedge clk);
    $display("covered %0d live ticks, %0d paused ticks, %0d reads (%0d past the last column)",
             n_ticks, n_frozen, n_reads, n_far_reads);
    $display("across %0d register settings, %0d results checked, %0d mismatches",
             n_settings, n_results, n_errors);
    if (n_errors == 0 && sample_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d items taken of %0d, %0d results pending", n_taken, n_queued,
             sample_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
